// ===== rtl/mmrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mmrc_pkg;

  localparam int ADDR_W  = 52;
  localparam int END_W   = 53;
  localparam int SUM_W   = 60;
  localparam int TYPE_W  = 8;
  localparam int CNT_W   = 8;
  localparam int SLOT_W  = 7;
  localparam int CFG_IDX_W = 3;

  localparam int MAP_SLOTS = 128;

  localparam int IN_DATA_W  = 2 * ADDR_W + TYPE_W;
  localparam int IN_BYTES_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = SLOT_W + 2 * ADDR_W + TYPE_W + SUM_W + END_W + CNT_W;
  localparam int OUT_BYTES_W = ((OUT_DATA_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] SLOT_CAP =
    (MAP_SLOTS < 255) ? CNT_W'(MAP_SLOTS) : CNT_W'(255);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USABLE_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGINAL_COUNT = 3'd4;

  localparam logic [TYPE_W-1:0] USABLE_CODE_RST   = 8'd1;
  localparam logic [TYPE_W-1:0] RESERVED_CODE_RST = 8'd2;

endpackage
`default_nettype wire

// ===== rtl/memory_map_region_clipper_top.sv =====
// An entry passes through the input, clip and output registers in that order.
// Throughput: one entry per cycle unless the output stalls; a split entry holds
// the output until both of its results leave through the single output register.
// Reset (rst, synchronous): pipeline empty, map-start set, totals and counters cleared,
// configuration registers back to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module memory_map_region_clipper_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [mmrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mmrc_pkg::ADDR_W-1:0]       cfg_data,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // region_base, region_length, region_type
  input  wire logic [mmrc_pkg::IN_BYTES_W-1:0]   s_axis_tdata,
  // final_entry
  input  wire logic                              s_axis_tlast,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // slot_index, out_base, out_length, out_type, usable_total, highest_end, entry_count
  output      logic [mmrc_pkg::OUT_BYTES_W-1:0]  m_axis_tdata,
  // is_added
  output      logic                              m_axis_tuser,
  // last_result
  output      logic                              m_axis_tlast
);
  import mmrc_pkg::*;

  logic [ADDR_W-1:0] window_start;
  logic [ADDR_W-1:0] window_end;
  logic [TYPE_W-1:0] usable_code;
  logic [TYPE_W-1:0] reserved_code;
  logic [CNT_W-1:0]  original_count;

  logic [CNT_W-1:0] item_counter;
  logic [CNT_W-1:0] add_slot;
  logic [SUM_W-1:0] sum_usable;
  logic [END_W-1:0] max_end;
  logic             map_start;

  logic              a_valid;
  logic [ADDR_W-1:0] a_base;
  logic [ADDR_W-1:0] a_len;
  logic [END_W-1:0]  a_end;
  logic [TYPE_W-1:0] a_type;
  logic              a_last;

  logic              b_valid;
  logic              b_cover;
  logic              b_keep_lo;
  logic              b_acct;
  logic [ADDR_W-1:0] b_base;
  logic [ADDR_W-1:0] b_lo;
  logic [ADDR_W-1:0] b_hi;
  logic [ADDR_W-1:0] b_nc_base;
  logic [ADDR_W-1:0] b_nc_len;
  logic [TYPE_W-1:0] b_nc_type;
  logic              b_last;

  logic              o_valid;
  logic              o_phase;
  logic              o_has_add;
  logic              o_last;
  logic [SLOT_W-1:0] o_slot;
  logic [ADDR_W-1:0] o_base;
  logic [ADDR_W-1:0] o_len;
  logic [TYPE_W-1:0] o_type;
  logic [SLOT_W-1:0] o_add_slot;
  logic [ADDR_W-1:0] o_add_base;
  logic [ADDR_W-1:0] o_add_len;
  logic [TYPE_W-1:0] o_add_type;
  logic [SUM_W-1:0]  o_sum;
  logic [END_W-1:0]  o_max;
  logic [CNT_W-1:0]  o_count;

  logic m_hs;
  logic o_free;
  logic b_adv;
  logic a_adv;
  logic s_hs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start   <= '0;
      window_end     <= '0;
      usable_code    <= USABLE_CODE_RST;
      reserved_code  <= RESERVED_CODE_RST;
      original_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_START:   window_start   <= cfg_data;
        REG_WINDOW_END:     window_end     <= cfg_data;
        REG_USABLE_CODE:    usable_code    <= cfg_data[TYPE_W-1:0];
        REG_RESERVED_CODE:  reserved_code  <= cfg_data[TYPE_W-1:0];
        REG_ORIGINAL_COUNT: original_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_hs   = m_axis_tvalid && m_axis_tready;
  assign o_free = !o_valid || (m_hs && (o_phase || !o_has_add));
  assign b_adv  = b_valid && o_free;
  assign a_adv  = a_valid && (!b_valid || b_adv);
  assign s_axis_tready = !a_valid || a_adv;
  assign s_hs   = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_hs) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
    if (s_hs) begin
      a_base <= s_axis_tdata[ADDR_W-1:0];
      a_len  <= s_axis_tdata[2*ADDR_W-1:ADDR_W];
      a_type <= s_axis_tdata[2*ADDR_W+TYPE_W-1:2*ADDR_W];
      a_last <= s_axis_tlast;
      a_end  <= {1'b0, s_axis_tdata[ADDR_W-1:0]} + {1'b0, s_axis_tdata[2*ADDR_W-1:ADDR_W]};
    end
  end

  // clip against the window
  logic              c_usable;
  logic              c_cover;
  logic              c_tstart;
  logic              c_tend;
  logic              c_inside;
  logic [ADDR_W-1:0] c_lo;
  logic [END_W-1:0]  c_hi_raw;
  logic [ADDR_W-1:0] c_hi;
  logic [ADDR_W-1:0] c_nc_base;
  logic [ADDR_W-1:0] c_nc_len;
  logic [TYPE_W-1:0] c_nc_type;

  always_comb begin
    c_usable = a_type == usable_code;
    c_cover  = (a_base < window_start) && (a_end > {1'b0, window_end});
    c_tstart = (a_base < window_start) && (a_end > {1'b0, window_start});
    c_tend   = (a_base < window_end) && (a_end > {1'b0, window_end});
    c_inside = (a_base >= window_start) && (a_end <= {1'b0, window_end});
    c_lo     = window_start - a_base;
    c_hi_raw = a_end - {1'b0, window_end};
    c_hi     = c_hi_raw[END_W-1] ? '1 : c_hi_raw[ADDR_W-1:0];
    c_nc_base = a_base;
    c_nc_len  = a_len;
    c_nc_type = a_type;
    if (c_usable && !c_cover) begin
      if (c_tstart) begin
        c_nc_len = c_lo;
      end else if (c_tend) begin
        c_nc_base = window_end;
        c_nc_len  = c_hi;
      end else if (c_inside) begin
        c_nc_type = reserved_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
    if (a_adv) begin
      b_cover   <= c_usable && c_cover;
      b_keep_lo <= c_lo > c_hi;
      b_acct    <= c_usable && (c_cover || (c_nc_type == usable_code));
      b_base    <= a_base;
      b_lo      <= c_lo;
      b_hi      <= c_hi;
      b_nc_base <= c_nc_base;
      b_nc_len  <= c_nc_len;
      b_nc_type <= c_nc_type;
      b_last    <= a_last;
    end
  end

  // slot choice and running totals
  logic [CNT_W-1:0]  e_cnt;
  logic [CNT_W-1:0]  e_slot;
  logic [SUM_W-1:0]  e_sum;
  logic [END_W-1:0]  e_max;
  logic              added;
  logic [ADDR_W-1:0] p_base;
  logic [ADDR_W-1:0] p_len;
  logic [SUM_W+1:0]  sum_raw;
  logic [SUM_W-1:0]  sum_next;
  logic [END_W-1:0]  end_p;
  logic [END_W-1:0]  end_a;
  logic [END_W-1:0]  max_next;
  logic [CNT_W-1:0]  slot_next;

  always_comb begin
    e_cnt  = map_start ? '0 : item_counter;
    e_slot = map_start ? original_count : add_slot;
    e_sum  = map_start ? '0 : sum_usable;
    e_max  = map_start ? '0 : max_end;
    added  = b_cover && (e_slot < SLOT_CAP);
    p_base = b_nc_base;
    p_len  = b_nc_len;
    if (b_cover) begin
      if (added || b_keep_lo) begin
        p_base = b_base;
        p_len  = b_lo;
      end else begin
        p_base = window_end;
        p_len  = b_hi;
      end
    end
    sum_raw = {2'b00, e_sum}
            + (b_acct ? (SUM_W+2)'(p_len) : '0)
            + (added ? (SUM_W+2)'(b_hi) : '0);
    sum_next = (sum_raw > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : sum_raw[SUM_W-1:0];
    end_p = {1'b0, p_base} + {1'b0, p_len};
    end_a = {1'b0, window_end} + {1'b0, b_hi};
    max_next = e_max;
    if (b_acct && (end_p > max_next)) begin
      max_next = end_p;
    end
    if (added && (end_a > max_next)) begin
      max_next = end_a;
    end
    slot_next = e_slot + CNT_W'(added);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_counter <= '0;
      add_slot     <= '0;
      sum_usable   <= '0;
      max_end      <= '0;
      map_start    <= 1'b1;
    end else if (b_adv) begin
      item_counter <= e_cnt + CNT_W'(1);
      add_slot     <= slot_next;
      sum_usable   <= sum_next;
      max_end      <= max_next;
      map_start    <= b_last;
    end
  end

  // output register, one or two results per entry
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_phase <= 1'b0;
    end else if (b_adv) begin
      o_valid <= 1'b1;
      o_phase <= 1'b0;
    end else if (m_hs) begin
      if (!o_phase && o_has_add) begin
        o_phase <= 1'b1;
      end else begin
        o_valid <= 1'b0;
      end
    end
    if (b_adv) begin
      o_has_add  <= added;
      o_last     <= b_last;
      o_slot     <= e_cnt[SLOT_W-1:0];
      o_base     <= p_base;
      o_len      <= p_len;
      o_type     <= b_nc_type;
      o_add_slot <= e_slot[SLOT_W-1:0];
      o_add_base <= window_end;
      o_add_len  <= b_hi;
      o_add_type <= usable_code;
      o_sum      <= sum_next;
      o_max      <= max_next;
      o_count    <= slot_next;
    end
  end

  logic [OUT_DATA_W-1:0] o_data;

  always_comb begin
    if (o_phase) begin
      o_data = {o_count, o_max, o_sum, o_add_type, o_add_len, o_add_base, o_add_slot};
    end else begin
      o_data = {o_count, o_max, o_sum, o_type, o_len, o_base, o_slot};
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = OUT_BYTES_W'(o_data);
  assign m_axis_tuser  = o_phase;
  assign m_axis_tlast  = o_last && (o_phase || !o_has_add);

endmodule
`default_nettype wire

// ===== rtl/mmrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mmrc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [mmrc_pkg::OUT_BYTES_W-1:0]  m_axis_tdata,
  input wire logic                              m_axis_tuser,
  input wire logic                              m_axis_tlast
);
  import mmrc_pkg::*;

  logic [SLOT_W-1:0] slot_f;
  logic [ADDR_W-1:0] base_f;
  logic [ADDR_W-1:0] len_f;
  logic [END_W-1:0]  high_f;
  logic [CNT_W-1:0]  count_f;
  logic [CNT_W-1:0]  count_m1;
  logic [END_W-1:0]  piece_end;

  assign slot_f    = m_axis_tdata[SLOT_W-1:0];
  assign base_f    = m_axis_tdata[SLOT_W+ADDR_W-1:SLOT_W];
  assign len_f     = m_axis_tdata[SLOT_W+2*ADDR_W-1:SLOT_W+ADDR_W];
  assign high_f    = m_axis_tdata[OUT_DATA_W-CNT_W-1:OUT_DATA_W-CNT_W-END_W];
  assign count_f   = m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-CNT_W];
  assign count_m1  = count_f - CNT_W'(1);
  assign piece_end = {1'b0, base_f} + {1'b0, len_f};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled transaction changed");

  a_added_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> slot_f == count_m1[SLOT_W-1:0])
    else $error("added entry slot does not match entry count");

  a_added_extent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (len_f != '0) && (high_f >= piece_end))
    else $error("added entry beyond highest end or empty");

endmodule

bind memory_map_region_clipper_top mmrc_checker u_mmrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== bench/memory_map_region_clipper_top_tb.sv =====
`timescale 1ns / 1ps
module memory_map_region_clipper_top_tb;
  import mmrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 118;
  localparam int LONG_MAP_ITEMS = 270;
  localparam logic [63:0] AMAX = (64'd1 << ADDR_W) - 1;
  localparam int OFS_BASE = SLOT_W;
  localparam int OFS_LEN = OFS_BASE + ADDR_W;
  localparam int OFS_TYPE = OFS_LEN + ADDR_W;
  localparam int OFS_SUM = OFS_TYPE + TYPE_W;
  localparam int OFS_HIGH = OFS_SUM + SUM_W;
  localparam int OFS_COUNT = OFS_HIGH + END_W;

  typedef struct {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic [TYPE_W-1:0] rtype;
    logic fin;
  } region_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic [TYPE_W-1:0] rtype;
    logic added;
    logic [SUM_W-1:0] total;
    logic [END_W-1:0] high_end;
    logic [CNT_W-1:0] count;
    logic last;
  } clip_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_BYTES_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_BYTES_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  memory_map_region_clipper_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  logic [63:0] win_lo = '0;
  logic [63:0] win_hi = '0;
  logic [TYPE_W-1:0] usable_c = USABLE_CODE_RST;
  logic [TYPE_W-1:0] reserved_c = RESERVED_CODE_RST;
  logic [CNT_W-1:0] orig_cnt = '0;

  logic map_fresh = 1'b1;
  logic [CNT_W-1:0] item_cnt = '0;
  logic [CNT_W-1:0] spare_slot = '0;
  logic [SUM_W-1:0] usable_sum = '0;
  logic [END_W-1:0] end_max = '0;

  region_t pending_regions[$];
  clip_t expected_clips[$];
  region_t cur_region;
  bit region_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int unsigned cycles = 0;

  function automatic logic [63:0] cap_len(logic [63:0] v);
    return (v > AMAX) ? AMAX : v;
  endfunction

  task automatic add_usable(logic [63:0] b, logic [63:0] l);
    logic [63:0] stop;
    logic [63:0] acc;
    stop = b + l;
    acc = {4'b0, usable_sum} + l;
    usable_sum = (acc > {4'b0, SUM_MAX}) ? SUM_MAX : acc[SUM_W-1:0];
    if (stop[END_W-1:0] > end_max) end_max = stop[END_W-1:0];
  endtask

  task automatic clip_region(region_t r);
    logic [63:0] b;
    logic [63:0] l;
    logic [63:0] stop;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] add_b;
    logic [63:0] add_l;
    logic [TYPE_W-1:0] t;
    logic [CNT_W-1:0] new_slot;
    logic [SLOT_W-1:0] slot;
    logic split;
    clip_t res;
    if (map_fresh) begin
      item_cnt = '0;
      usable_sum = '0;
      end_max = '0;
      spare_slot = orig_cnt;
      map_fresh = 1'b0;
    end
    b = 64'(r.base);
    l = 64'(r.len);
    t = r.rtype;
    stop = b + l;
    split = 1'b0;
    new_slot = '0;
    add_b = '0;
    add_l = '0;
    slot = item_cnt[SLOT_W-1:0];
    if (t == usable_c) begin
      if (b < win_lo && stop > win_hi) begin
        lo = win_lo - b;
        hi = cap_len(stop - win_hi);
        if (spare_slot < SLOT_CAP) begin
          l = lo;
          split = 1'b1;
          new_slot = spare_slot;
          add_b = win_hi;
          add_l = hi;
          spare_slot = spare_slot + CNT_W'(1);
        end else if (lo > hi) begin
          l = lo;
        end else begin
          b = win_hi;
          l = hi;
        end
      end else if (b < win_lo && stop > win_lo) begin
        l = win_lo - b;
      end else if (b < win_hi && stop > win_hi) begin
        b = win_hi;
        l = cap_len(stop - win_hi);
      end else if (b >= win_lo && stop <= win_hi) begin
        t = reserved_c;
      end
      if (t == usable_c) add_usable(b, l);
      if (split) add_usable(add_b, add_l);
    end
    res.slot = slot;
    res.base = b[ADDR_W-1:0];
    res.len = l[ADDR_W-1:0];
    res.rtype = t;
    res.added = 1'b0;
    res.total = usable_sum;
    res.high_end = end_max;
    res.count = spare_slot;
    res.last = r.fin && !split;
    expected_clips.push_back(res);
    if (split) begin
      res.slot = new_slot[SLOT_W-1:0];
      res.base = add_b[ADDR_W-1:0];
      res.len = add_l[ADDR_W-1:0];
      res.rtype = usable_c;
      res.added = 1'b1;
      res.last = r.fin;
      expected_clips.push_back(res);
    end
    item_cnt = item_cnt + CNT_W'(1);
    if (r.fin) map_fresh = 1'b1;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      clip_region(cur_region);
      region_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || region_taken) begin
      region_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_regions.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 13);
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_region = pending_regions.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_BYTES_W'({cur_region.rtype, cur_region.len, cur_region.base});
        s_axis_tlast <= cur_region.fin;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    clip_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_clips.size() == 0) begin
        $error("result transaction with no expected entry pending");
        mismatches++;
      end else begin
        want = expected_clips.pop_front();
        check_field("slot_index", 64'(want.slot), 64'(m_axis_tdata[0 +: SLOT_W]));
        check_field("out_base", 64'(want.base), 64'(m_axis_tdata[OFS_BASE +: ADDR_W]));
        check_field("out_length", 64'(want.len), 64'(m_axis_tdata[OFS_LEN +: ADDR_W]));
        check_field("out_type", 64'(want.rtype), 64'(m_axis_tdata[OFS_TYPE +: TYPE_W]));
        check_field("usable_total", 64'(want.total), 64'(m_axis_tdata[OFS_SUM +: SUM_W]));
        check_field("highest_end", 64'(want.high_end),
                    64'(m_axis_tdata[OFS_HIGH +: END_W]));
        check_field("entry_count", 64'(want.count), 64'(m_axis_tdata[OFS_COUNT +: CNT_W]));
        check_field("is_added", 64'(want.added), 64'(m_axis_tuser));
        check_field("last_result", 64'(want.last), 64'(m_axis_tlast));
      end
    end
  end

  function automatic logic [63:0] rand52();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v & AMAX;
  endfunction

  function automatic logic [63:0] rand_between(logic [63:0] lo, logic [63:0] hi);
    if (hi <= lo) return lo;
    return lo + ({$urandom, $urandom} % (hi - lo + 1));
  endfunction

  function automatic logic [63:0] pick_point();
    logic [63:0] lo;
    logic [63:0] hi;
    lo = (win_lo < win_hi) ? win_lo : win_hi;
    hi = (win_lo < win_hi) ? win_hi : win_lo;
    case ($urandom_range(0, 11))
      0: return 64'd0;
      1: return (win_lo == 0) ? 64'd0 : win_lo - 1;
      2: return win_lo;
      3: return win_lo + 1;
      4: return (win_hi == 0) ? 64'd0 : win_hi - 1;
      5: return win_hi;
      6: return win_hi + 1;
      7: return AMAX;
      8: return rand_between(0, win_lo);
      9: return rand_between(lo, hi);
      10: return rand_between(win_hi, AMAX);
      default: return rand52();
    endcase
  endfunction

  task automatic push_region(logic [63:0] b, logic [63:0] l, logic [7:0] t, logic fin);
    region_t r;
    r.base = b[ADDR_W-1:0];
    r.len = l[ADDR_W-1:0];
    r.rtype = t;
    r.fin = fin;
    pending_regions.push_back(r);
  endtask

  task automatic push_random_region(logic fin);
    logic [63:0] a;
    logic [63:0] z;
    logic [63:0] tmp;
    logic [7:0] t;
    int pick;
    if ($urandom_range(0, 9) == 0) begin
      a = rand52();
      z = a + rand52();
    end else begin
      a = pick_point();
      z = pick_point();
      if (z < a) begin
        tmp = a;
        a = z;
        z = tmp;
      end
      if (a > AMAX) a = AMAX;
    end
    pick = $urandom_range(0, 19);
    if (pick < 2) t = 8'($urandom_range(0, 255));
    else if (pick == 2) t = reserved_c;
    else t = usable_c;
    push_region(a, cap_len(z - a), t, fin);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_regions.size() != 0 || s_axis_tvalid || expected_clips.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[ADDR_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WINDOW_START: win_lo = 64'(val[ADDR_W-1:0]);
      REG_WINDOW_END: win_hi = 64'(val[ADDR_W-1:0]);
      REG_USABLE_CODE: usable_c = val[TYPE_W-1:0];
      REG_RESERVED_CODE: reserved_c = val[TYPE_W-1:0];
      REG_ORIGINAL_COUNT: orig_cnt = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_map(logic [63:0] s, logic [63:0] e, logic [7:0] u, logic [7:0] r,
                         logic [7:0] orig);
    wait_idle();
    write_reg(REG_WINDOW_START, s);
    write_reg(REG_WINDOW_END, e);
    write_reg(REG_USABLE_CODE, 64'(u));
    write_reg(REG_RESERVED_CODE, 64'(r));
    write_reg(REG_ORIGINAL_COUNT, 64'(orig));
  endtask

  initial begin : stimulus
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] b;
    logic [7:0] u;
    int map_left;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    set_map(64'h1000_0000, 64'h3000_0000, 8'd1, 8'd2, 8'd126);
    push_region(64'h0800_0000, 64'h3000_0000, 8'd1, 1'b0);
    push_region(64'h0800_0000, 64'h3000_0000, 8'd1, 1'b0);
    push_region(64'h0, 64'h3100_0000, 8'd1, 1'b0);
    push_region(64'h0F00_0000, 64'h3100_0000, 8'd1, 1'b0);
    push_region(64'h0800_0000, 64'h3000_0000, 8'd1, 1'b0);
    push_region(64'h0800_0000, 64'h1000_0000, 8'd1, 1'b0);
    push_region(64'h2000_0000, 64'h2000_0000, 8'd1, 1'b0);
    push_region(64'h1800_0000, 64'h100, 8'd1, 1'b0);
    push_region(64'h1000_0000, 64'h2000_0000, 8'd1, 1'b0);
    push_region(64'h0, 64'h1000_0000, 8'd1, 1'b0);
    push_region(64'h3000_0000, 64'h1000, 8'd1, 1'b0);
    push_region(64'h1800_0000, 64'h100, 8'd3, 1'b0);
    push_region(AMAX, AMAX, 8'd1, 1'b0);
    push_region(64'h0, 64'h0, 8'd1, 1'b1);

    set_map(64'h100, 64'h200, 8'h5A, 8'h5A, 8'd0);
    push_region(64'h140, 64'h20, 8'h5A, 1'b0);
    push_region(64'h140, 64'h20, 8'hA5, 1'b0);
    push_region(64'h80, 64'h200, 8'h5A, 1'b1);

    set_map(AMAX, 64'h0, 8'hFF, 8'h00, 8'd128);
    push_region(AMAX - 1, AMAX, 8'hFF, 1'b0);
    push_region(64'h0, AMAX, 8'hFF, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s = rand52();
      e = rand_between(s, AMAX);
      u = 8'($urandom_range(0, 255));
      case (p)
        0: set_map(s, e, u, 8'($urandom_range(0, 255)), 8'd0);
        1: set_map(64'h0, AMAX, u, 8'($urandom_range(0, 255)), 8'd128);
        2: set_map(s, e, u, 8'($urandom_range(0, 255)), 8'd120);
        3: set_map(e, s, u, u, 8'($urandom_range(0, 128)));
        4: set_map(64'h0, 64'h0, 8'hFF, 8'h00, 8'($urandom_range(0, 128)));
        5: set_map(s, e, u, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 128)));
        6: set_map(s, s, u, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 128)));
        7: begin
          s = 64'($urandom_range(1, 4096));
          set_map(s, s + 64'($urandom_range(0, 4096)), u, 8'($urandom_range(0, 255)),
                  8'd127);
        end
        8: set_map(AMAX, AMAX, u, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 128)));
        default: set_map(s, e, u, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 128)));
      endcase
      idle_on = (p % 4 != 1) && (p != RANDOM_PHASES - 1);
      if (p == 8) begin
        for (int i = 0; i < LONG_MAP_ITEMS; i++) begin
          b = 64'($urandom_range(0, 65536));
          push_region(b, AMAX - b - 64'($urandom_range(0, 255)), usable_c,
                      i == LONG_MAP_ITEMS - 1);
        end
      end else begin
        map_left = $urandom_range(1, 40);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
          map_left--;
          push_random_region(map_left == 0 || i == PHASE_ITEMS - 1);
          if (map_left == 0) map_left = $urandom_range(1, 40);
        end
      end
      if (p == 2) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
